// File: design/assert_macros.svh
// assertion helpers, empty when synthesised
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/mpqs_pkg.sv
`timescale 1ns / 1ps

package mpqs_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [31:0] NONE32 = 32'hFFFF_FFFF;

  // event kinds
  localparam logic [1:0] MODE_ARRIVE = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_QUANT  = 2'd2;

  // policy codes
  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_PSJF = 3'd2;
  localparam logic [2:0] POL_PRI  = 3'd3;
  localparam logic [2:0] POL_PPRI = 3'd4;

  typedef struct packed {
    logic [7:0]  id;
    logic [30:0] arrival;
    logic [30:0] run_total;
    logic [31:0] remaining;
    logic [7:0]  prio;
    logic [31:0] first_run;
    logic [31:0] last_sched;
  } entry_t;

endpackage

// File: design/multi_policy_ready_queue_scheduler.sv
// Ready-queue scheduler; one event in, one result out per event.
// Arrival runs a key scan then a shift, two steps per entry through the registered-read queue memory.
// Throughput: one event at a time; a new event is taken once the previous result is queued.
// Reset: synchronous, clears the job count, policy and handshake state; queue memory is not
// cleared, only entries below the count are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_policy_ready_queue_scheduler import mpqs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         policy_wr_en,
  input  logic [2:0]   policy_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // job_id, now, run_time, job_priority, zero pad
  input  logic [1:0]   s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata    // run_valid, run_job, finish_found, turnaround,
                                  // waiting, response, queue_full, zero pad
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_A_CHG  = 4'd1;
  localparam logic [3:0] ST_A_SCAN = 4'd2;
  localparam logic [3:0] ST_A_CMP  = 4'd3;
  localparam logic [3:0] ST_A_SHRD = 4'd4;
  localparam logic [3:0] ST_A_SHWR = 4'd5;
  localparam logic [3:0] ST_A_PUT  = 4'd6;
  localparam logic [3:0] ST_F_SCAN = 4'd7;
  localparam logic [3:0] ST_F_CMP  = 4'd8;
  localparam logic [3:0] ST_D_RD   = 4'd9;
  localparam logic [3:0] ST_D_WR   = 4'd10;
  localparam logic [3:0] ST_Q_HEAD = 4'd11;
  localparam logic [3:0] ST_Q_PUT  = 4'd12;
  localparam logic [3:0] ST_H_RD   = 4'd13;
  localparam logic [3:0] ST_H_WR   = 4'd14;
  localparam logic [3:0] ST_OUT    = 4'd15;

  logic [3:0]    state;
  logic [2:0]    policy;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [7:0]    head_id;

  // latched event
  logic [1:0]    ev_mode;
  logic [7:0]    ev_job;
  logic [30:0]   ev_now;
  logic [30:0]   ev_run;
  logic [7:0]    ev_prio;

  // result fields
  logic          res_found;
  logic [30:0]   res_turn;
  logic [31:0]   res_wait;
  logic [30:0]   res_resp;
  logic          res_full;

  entry_t        hold;
  entry_t        mem [DEPTH];
  entry_t        rd_data;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  entry_t        nj;
  entry_t        nj_in;
  entry_t        charged;
  entry_t        head_fix;
  entry_t        rotated;
  logic          sorted;
  logic          protect;
  logic          preempt;
  logic          scan_le;
  logic [1:0]    cmp_h;
  logic [1:0]    cmp_s;
  logic          s_xfer;
  logic          out_free;
  logic          full_arrive;
  logic [31:0]   now32;
  logic [31:0]   diff;

  // key comparison under the current policy: {a before b, keys equal}
  function automatic logic [1:0] key_cmp(input logic [2:0] pol, input entry_t a, input entry_t b);
    logic lt;
    logic eq;
    lt = 1'b0;
    eq = 1'b1;
    unique case (pol)
      POL_SJF: begin
        lt = a.run_total < b.run_total;
        eq = a.run_total == b.run_total;
      end
      POL_PSJF: begin
        lt = $signed(a.remaining) < $signed(b.remaining);
        eq = a.remaining == b.remaining;
      end
      POL_PRI, POL_PPRI: begin
        lt = a.prio < b.prio;
        eq = a.prio == b.prio;
      end
      default: begin
        lt = 1'b0;
        eq = 1'b1;
      end
    endcase
    return {lt, eq};
  endfunction

  assign s_xfer   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign sorted   = (policy == POL_SJF) || (policy == POL_PSJF) ||
                    (policy == POL_PRI) || (policy == POL_PPRI);
  assign protect  = (policy == POL_SJF) || (policy == POL_PRI);
  assign now32    = {1'b0, ev_now};
  assign full_arrive = s_xfer && (s_tuser == MODE_ARRIVE) && (count == CW'(DEPTH));

  // new job from the latched event and straight from the port
  always_comb begin
    nj            = '0;
    nj.id         = ev_job;
    nj.arrival    = ev_now;
    nj.run_total  = ev_run;
    nj.remaining  = {1'b0, ev_run};
    nj.prio       = ev_prio;
    nj.first_run  = NONE32;
    nj.last_sched = NONE32;
    nj_in            = '0;
    nj_in.id         = s_tdata[7:0];
    nj_in.arrival    = s_tdata[38:8];
    nj_in.run_total  = s_tdata[69:39];
    nj_in.remaining  = {1'b0, s_tdata[69:39]};
    nj_in.prio       = s_tdata[77:70];
    nj_in.first_run  = {1'b0, s_tdata[38:8]};
    nj_in.last_sched = {1'b0, s_tdata[38:8]};
  end

  // head charge on arrival plus first run if still unset, head fix-up, and rotated head for quantum expiry
  always_comb begin
    charged = rd_data;
    if (!rd_data.last_sched[31]) begin
      charged.remaining  = rd_data.remaining - (now32 - rd_data.last_sched);
      charged.last_sched = now32;
    end
    if (rd_data.first_run[31]) begin
      charged.first_run = now32;
    end
    head_fix = rd_data;
    head_fix.last_sched = now32;
    if (rd_data.first_run[31]) begin
      head_fix.first_run = now32;
    end
    rotated = rd_data;
    rotated.last_sched = NONE32;
  end

  // ordering decisions
  always_comb begin
    cmp_h   = key_cmp(policy, nj, charged);
    preempt = cmp_h[1] || (cmp_h[0] && (ev_now < charged.arrival));
    cmp_s   = key_cmp(policy, rd_data, nj);
    scan_le = cmp_s[1] || (cmp_s[0] && (rd_data.arrival <= ev_now));
  end

  // finish statistics
  assign diff = now32 - {1'b0, rd_data.arrival};

  // memory address and write selection
  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wa      = '0;
    wd      = rd_data;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer && s_tuser == MODE_ARRIVE && count == '0) begin
          we = 1'b1;
          wd = nj_in;
        end
      end
      ST_A_CHG: begin
        we = 1'b1;
        wd = charged;
      end
      ST_A_SCAN, ST_F_SCAN: rd_addr = idx[AW-1:0];
      ST_A_SHRD: rd_addr = idx[AW-1:0] - AW'(1);
      ST_A_SHWR: begin
        we = 1'b1;
        wa = idx[AW-1:0];
        if (idx == CW'(1) && pos == '0) begin
          if (rd_data.first_run == now32) begin
            wd.first_run = NONE32;
          end
          wd.last_sched = NONE32;
        end
      end
      ST_A_PUT: begin
        we = 1'b1;
        wa = pos[AW-1:0];
        wd = nj;
        if (pos == '0) begin
          wd.first_run  = now32;
          wd.last_sched = now32;
        end
      end
      ST_D_RD: rd_addr = idx[AW-1:0] + AW'(1);
      ST_D_WR: begin
        we = 1'b1;
        wa = idx[AW-1:0];
      end
      ST_Q_PUT: begin
        we = 1'b1;
        wa = AW'(count - CW'(1));
        wd = hold;
      end
      ST_H_WR: begin
        we = 1'b1;
        wd = head_fix;
      end
      default: rd_addr = '0;
    endcase
  end

  // queue memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FCFS;
    end else if (policy_wr_en) begin
      policy <= policy_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            ev_mode   <= s_tuser;
            ev_job    <= s_tdata[7:0];
            ev_now    <= s_tdata[38:8];
            ev_run    <= s_tdata[69:39];
            ev_prio   <= s_tdata[77:70];
            res_found <= 1'b0;
            res_turn  <= '0;
            res_wait  <= '0;
            res_resp  <= '0;
            res_full  <= full_arrive;
            idx       <= '0;
            unique case (s_tuser)
              MODE_ARRIVE: begin
                if (count == CW'(DEPTH)) begin
                  state <= ST_OUT;
                end else if (count == '0) begin
                  count   <= CW'(1);
                  head_id <= s_tdata[7:0];
                  state   <= ST_OUT;
                end else begin
                  state <= ST_A_CHG;
                end
              end
              MODE_FINISH: state <= (count != '0) ? ST_F_SCAN : ST_OUT;
              MODE_QUANT:  state <= (count > CW'(1)) ? ST_Q_HEAD : ST_OUT;
              default:     state <= ST_OUT;
            endcase
          end
        end
        ST_A_CHG: begin
          if (!sorted) begin
            pos   <= count;
            idx   <= count;
            state <= ST_A_SHRD;
          end else if (!protect && preempt) begin
            pos   <= '0;
            idx   <= count;
            state <= ST_A_SHRD;
          end else if (count == CW'(1)) begin
            pos   <= CW'(1);
            idx   <= CW'(1);
            state <= ST_A_SHRD;
          end else begin
            idx   <= CW'(1);
            state <= ST_A_SCAN;
          end
        end
        ST_A_SCAN: state <= ST_A_CMP;
        ST_A_CMP: begin
          if (!scan_le) begin
            pos   <= idx;
            idx   <= count;
            state <= ST_A_SHRD;
          end else if (idx + CW'(1) == count) begin
            pos   <= count;
            idx   <= count;
            state <= ST_A_SHRD;
          end else begin
            idx   <= idx + CW'(1);
            state <= ST_A_SCAN;
          end
        end
        ST_A_SHRD: state <= (idx > pos) ? ST_A_SHWR : ST_A_PUT;
        ST_A_SHWR: begin
          idx   <= idx - CW'(1);
          state <= ST_A_SHRD;
        end
        ST_A_PUT: begin
          count <= count + CW'(1);
          if (pos == '0) begin
            head_id <= ev_job;
          end
          state <= ST_OUT;
        end
        ST_F_SCAN: state <= ST_F_CMP;
        ST_F_CMP: begin
          if (rd_data.id == ev_job) begin
            res_found <= 1'b1;
            res_turn  <= diff[30:0];
            res_wait  <= diff - {1'b0, rd_data.run_total};
            res_resp  <= rd_data.first_run[31] ? '0 :
                         31'(rd_data.first_run - {1'b0, rd_data.arrival});
            state     <= ST_D_RD;
          end else if (idx + CW'(1) == count) begin
            state <= ST_OUT;
          end else begin
            idx   <= idx + CW'(1);
            state <= ST_F_SCAN;
          end
        end
        ST_D_RD: begin
          if (idx + CW'(1) < count) begin
            state <= ST_D_WR;
          end else if (ev_mode == MODE_QUANT) begin
            state <= ST_Q_PUT;
          end else begin
            count <= count - CW'(1);
            state <= (count > CW'(1)) ? ST_H_RD : ST_OUT;
          end
        end
        ST_D_WR: begin
          idx   <= idx + CW'(1);
          state <= ST_D_RD;
        end
        ST_Q_HEAD: begin
          hold  <= rotated;
          idx   <= '0;
          state <= ST_D_RD;
        end
        ST_Q_PUT: state <= ST_H_RD;
        ST_H_RD:  state <= ST_H_WR;
        ST_H_WR: begin
          head_id <= rd_data.id;
          state   <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_full, res_resp, res_wait, res_turn, res_found,
                         (count != '0) ? head_id : 8'd0, (count != '0)};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "job count above queue depth")
  `ASSERT_NEXT(a_full_no_change, full_arrive, count == CW'(DEPTH), "rejected arrival changed count")
  `ASSERT_ALWAYS(a_flags_exclusive, !(m_tvalid && m_tdata[104] && m_tdata[9]), "full with finish")

endmodule
